// ----- hdl/counting_semaphore_fifo_assert.svh -----
// Assertion macros for the semaphore block.
`ifndef COUNTING_SEMAPHORE_FIFO_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_ASSERT_SVH

// Check a property while out of reset.
`define CSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/csf_pkg.sv -----
package csf_pkg;

  localparam int COUNT_W  = 17;
  localparam int ID_W     = 6;
  localparam int INIT_W   = 15;
  localparam int STATUS_W = 2;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 17'sd65535;
  localparam logic [INIT_W-1:0]         INIT_RESET = 15'd1;

  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  localparam logic REG_INIT_VALUE = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic              load;
    logic [INIT_W-1:0] value;
  } cfg_load_t;

endpackage

// ----- hdl/csf_if.sv -----
interface csf_in_if;
  import csf_pkg::*;

  logic            valid;
  logic            ready;
  logic            op;
  logic [ID_W-1:0] thread_id;

  modport source (output valid, op, thread_id, input ready);
  modport sink   (input valid, op, thread_id, output ready);
endinterface

interface csf_out_if;
  import csf_pkg::*;

  logic                valid;
  logic                ready;
  logic                must_block;
  logic                woke_valid;
  logic [ID_W-1:0]     woke_thread;
  logic [STATUS_W-1:0] status;

  modport source (output valid, must_block, woke_valid, woke_thread, status, input ready);
  modport sink   (input valid, must_block, woke_valid, woke_thread, status, output ready);
endinterface

// ----- hdl/csf_store.sv -----
module csf_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [csf_pkg::ID_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic [csf_pkg::ID_W-1:0] rdata
);
  import csf_pkg::*;

  logic [ID_W-1:0] mem_r [DEPTH];
  logic [ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/csf_ctrl.sv -----
module csf_ctrl #(
  parameter int MAX_THREADS = 64,
  parameter int AW          = $clog2(MAX_THREADS),
  parameter int WCNT_W      = $clog2(MAX_THREADS + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  csf_pkg::cfg_load_t       cfg,
  csf_in_if.sink                   in_ch,
  csf_out_if.source                out_ch,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [csf_pkg::ID_W-1:0] mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  logic [csf_pkg::ID_W-1:0] mem_rdata
);
  import csf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  localparam logic [AW-1:0]     LAST_IDX = AW'(MAX_THREADS - 1);
  localparam logic [WCNT_W-1:0] FULL_CNT = WCNT_W'(MAX_THREADS);

  state_t                     state_r, state_nxt;
  logic signed [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]              head_r, head_nxt;
  logic [AW-1:0]              tail_r, tail_nxt;
  logic [WCNT_W-1:0]          wcnt_r, wcnt_nxt;
  logic                       blk_r, blk_nxt;
  logic                       woke_r, woke_nxt;
  status_t                    stat_r, stat_nxt;
  logic                       ovalid_r, ovalid_nxt;
  logic                       oblk_r, oblk_nxt;
  logic                       owoke_r, owoke_nxt;
  logic [ID_W-1:0]            otid_r, otid_nxt;
  status_t                    ostat_r, ostat_nxt;

  logic                       accept;
  logic                       load_out;
  logic signed [COUNT_W-1:0]  cnt_dec;
  logic signed [COUNT_W-1:0]  cnt_inc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load_out    = (state_r == S_RESP) && (!ovalid_r || out_ch.ready);
  assign cnt_dec     = cnt_r - 17'sd1;
  assign cnt_inc     = cnt_r + 17'sd1;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    wcnt_nxt   = wcnt_r;
    blk_nxt    = blk_r;
    woke_nxt   = woke_r;
    stat_nxt   = stat_r;
    ovalid_nxt = ovalid_r;
    oblk_nxt   = oblk_r;
    owoke_nxt  = owoke_r;
    otid_nxt   = otid_r;
    ostat_nxt  = ostat_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          blk_nxt   = 1'b0;
          woke_nxt  = 1'b0;
          stat_nxt  = ST_OK;
          state_nxt = S_RESP;
          if (in_ch.op == OP_WAIT) begin
            if (wcnt_r == FULL_CNT) begin
              stat_nxt = ST_FULL;
            end else begin
              cnt_nxt = cnt_dec;
              if (cnt_dec[COUNT_W-1]) begin
                mem_we   = 1'b1;
                tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + AW'(1);
                wcnt_nxt = wcnt_r + WCNT_W'(1);
                blk_nxt  = 1'b1;
              end
            end
          end else begin
            if (cnt_r == COUNT_MAX) begin
              stat_nxt = ST_SAT;
            end else begin
              cnt_nxt = cnt_inc;
              if ((cnt_inc[COUNT_W-1] || cnt_inc == '0) && wcnt_r != '0) begin
                mem_re   = 1'b1;
                head_nxt = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
                wcnt_nxt = wcnt_r - WCNT_W'(1);
                woke_nxt = 1'b1;
              end
            end
          end
        end
      end
      S_RESP: begin
        if (load_out) begin
          ovalid_nxt = 1'b1;
          oblk_nxt   = blk_r;
          owoke_nxt  = woke_r;
          otid_nxt   = woke_r ? mem_rdata : '0;
          ostat_nxt  = stat_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg.load) begin
      cnt_nxt  = COUNT_W'(cfg.value);
      head_nxt = '0;
      tail_nxt = '0;
      wcnt_nxt = '0;
    end
  end

  assign mem_waddr = tail_r;
  assign mem_wdata = in_ch.thread_id;
  assign mem_raddr = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= COUNT_W'(INIT_RESET);
      head_r   <= '0;
      tail_r   <= '0;
      wcnt_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      wcnt_r   <= wcnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
    blk_r   <= blk_nxt;
    woke_r  <= woke_nxt;
    stat_r  <= stat_nxt;
    oblk_r  <= oblk_nxt;
    owoke_r <= owoke_nxt;
    otid_r  <= otid_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.must_block  = oblk_r;
  assign out_ch.woke_valid  = owoke_r;
  assign out_ch.woke_thread = otid_r;
  assign out_ch.status      = ostat_r;

endmodule

// ----- hdl/counting_semaphore_fifo.sv -----
// Counting semaphore with a FIFO of blocked thread IDs. Each input word is a
// wait or a signal and yields one result word. In an operation, the accept
// cycle updates the count and indices and issues the queue memory write
// (wait) or read (signal), and the response state captures the read data
// into the output register once that register is free or being taken. The
// input is taken again while a result waits in that register. The count
// restarts from initial_value on reset and whenever initial_value is written,
// which also empties the queue; write it only while the block is idle.
module counting_semaphore_fifo #(
  parameter int MAX_THREADS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  csf_in_if.sink                     in_ch,
  csf_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [csf_pkg::APB_AW-1:0] paddr,
  input  logic [csf_pkg::APB_DW-1:0] pwdata,
  output logic [csf_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import csf_pkg::*;

  localparam int AW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

  logic [INIT_W-1:0] init_r;
  logic              reg_sel;
  logic              wr_en;
  cfg_load_t         cfg;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ID_W-1:0]   mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [ID_W-1:0]   mem_rdata;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_INIT_VALUE);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= INIT_RESET;
    end else if (wr_en) begin
      init_r <= pwdata[INIT_W-1:0];
    end
  end

  assign prdata    = reg_sel ? APB_DW'(init_r) : '0;
  assign cfg.load  = wr_en;
  assign cfg.value = pwdata[INIT_W-1:0];

  csf_ctrl #(
    .MAX_THREADS (MAX_THREADS),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  csf_store #(
    .DEPTH (MAX_THREADS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- hdl/csf_checker.sv -----
module csf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         must_block,
  input logic                         woke_valid,
  input logic [csf_pkg::ID_W-1:0]     woke_thread,
  input logic [csf_pkg::STATUS_W-1:0] status
);
  import csf_pkg::*;
`include "counting_semaphore_fifo_assert.svh"

  `CSF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `CSF_ASSERT(a_full_no_effect, out_valid && status == ST_FULL |-> !must_block && !woke_valid, "rejected wait reports an effect")
  `CSF_ASSERT(a_block_xor_wake, out_valid |-> !(must_block && woke_valid), "block and wake in one word")
  `CSF_ASSERT(a_woke_zero, out_valid && !woke_valid |-> woke_thread == '0, "woke_thread set without wake")
  `CSF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind counting_semaphore_fifo csf_checker u_csf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .must_block  (out_ch.must_block),
  .woke_valid  (out_ch.woke_valid),
  .woke_thread (out_ch.woke_thread),
  .status      (out_ch.status)
);

// ----- test/csf_checker.sv -----
`timescale 1ns / 100ps
module semaphore_checker #(
  parameter int MAX_THREADS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  csf_in_if                          in_ch,
  csf_out_if                         out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [csf_pkg::APB_AW-1:0] paddr,
  input  logic [csf_pkg::APB_DW-1:0] pwdata,
  output int                         mismatches,
  output int                         outstanding
);
  import csf_pkg::*;

  localparam logic [APB_AW-1:0] INIT_ADDR = {REG_INIT_VALUE, 2'b00};

  typedef struct packed {
    logic            must_block;
    logic            woke_valid;
    logic [ID_W-1:0] woke_thread;
    status_t         status;
  } sem_reply_t;

  logic signed [COUNT_W-1:0] sem_count;
  logic [ID_W-1:0]           blocked_ids[$];
  sem_reply_t                expected_replies[$];
  int                        fail_total = 0;

  assign mismatches = fail_total;

  function automatic void reload_semaphore(input logic [INIT_W-1:0] value);
    sem_count = $signed({{(COUNT_W - INIT_W){1'b0}}, value});
    blocked_ids.delete();
  endfunction

  function automatic sem_reply_t apply_sem_op(input logic op, input logic [ID_W-1:0] tid);
    sem_reply_t r;
    r.must_block  = 1'b0;
    r.woke_valid  = 1'b0;
    r.woke_thread = '0;
    r.status      = ST_OK;
    if (op == OP_WAIT) begin
      if (blocked_ids.size() >= MAX_THREADS) begin
        r.status = ST_FULL;
      end else begin
        sem_count = sem_count - 1;
        if (sem_count < 0) begin
          blocked_ids.push_back(tid);
          r.must_block = 1'b1;
        end
      end
    end else if (sem_count >= COUNT_MAX) begin
      r.status = ST_SAT;
    end else begin
      sem_count = sem_count + 1;
      if (sem_count <= 0 && blocked_ids.size() > 0) begin
        r.woke_valid  = 1'b1;
        r.woke_thread = blocked_ids.pop_front();
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_total++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    sem_reply_t want;
    if (!rst_n) begin
      reload_semaphore(INIT_RESET);
      expected_replies.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == INIT_ADDR) begin
        reload_semaphore(pwdata[INIT_W-1:0]);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected word: must_block %0b woke_valid %0b woke_thread %0d status %0d",
                   $time, out_ch.must_block, out_ch.woke_valid, out_ch.woke_thread,
                   out_ch.status);
        end else begin
          want = expected_replies.pop_front();
          check_field("must_block", want.must_block, out_ch.must_block);
          check_field("woke_valid", want.woke_valid, out_ch.woke_valid);
          check_field("woke_thread", want.woke_thread, out_ch.woke_thread);
          check_field("status", want.status, out_ch.status);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_replies.push_back(apply_sem_op(in_ch.op, in_ch.thread_id));
      end
    end
    outstanding <= expected_replies.size();
  end

endmodule

// ----- test/tb_counting_semaphore_fifo.sv -----
`timescale 1ns / 100ps
module tb_counting_semaphore_fifo;
  import csf_pkg::*;

  localparam int MAX_THREADS    = 64;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_WORDS    = 100;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int CLIMB_WORDS    = 16;
  localparam logic [APB_AW-1:0] INIT_ADDR = {REG_INIT_VALUE, 2'b00};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              hold_receiver = 1'b0;
  int                mismatches;
  int                outstanding;
  int                burst_left = 0;
  int                idle_cycles = 0;

  csf_in_if  in_ch();
  csf_out_if out_ch();

  counting_semaphore_fifo #(.MAX_THREADS(MAX_THREADS)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  semaphore_checker #(.MAX_THREADS(MAX_THREADS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        hold_receiver = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 0);
        2: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_word(input logic op, input logic [ID_W-1:0] tid);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.thread_id <= tid;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_init_value(input logic [INIT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= INIT_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_random_words(input int words);
    int seg_left;
    int wait_pct;
    seg_left = 0;
    wait_pct = 50;
    for (int i = 0; i < words; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 80);
        case ($urandom_range(0, 3))
          0: wait_pct = 15;
          1: wait_pct = 85;
          2: wait_pct = 50;
          default: wait_pct = 97;
        endcase
      end
      seg_left--;
      send_word(($urandom_range(0, 99) < wait_pct) ? OP_WAIT : OP_SIGNAL, ID_W'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [INIT_W-1:0] init;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_WAIT;
    in_ch.thread_id <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count starts at one: first wait passes, the next three block
    send_word(OP_WAIT, 6'd0);
    send_word(OP_WAIT, 6'd63);
    send_word(OP_WAIT, 6'd42);
    send_word(OP_WAIT, 6'd21);
    send_word(OP_SIGNAL, '1);
    send_word(OP_SIGNAL, '0);
    send_word(OP_SIGNAL, 6'd33);
    send_word(OP_SIGNAL, '0);
    send_word(OP_SIGNAL, '1);
    send_word(OP_WAIT, '1);
    drain_replies();

    // fill the waiter queue, hit full, wrap the indices
    write_init_value('0);
    for (int i = 0; i < MAX_THREADS; i++) send_word(OP_WAIT, ID_W'($urandom));
    send_word(OP_WAIT, '1);
    send_word(OP_WAIT, '0);
    send_word(OP_SIGNAL, '0);
    send_word(OP_WAIT, 6'd17);
    send_word(OP_WAIT, 6'd46);
    for (int i = 0; i < MAX_THREADS + 2; i++) send_word(OP_SIGNAL, ID_W'($urandom));
    for (int i = 0; i < 10; i++) send_word(OP_WAIT, ID_W'($urandom));
    drain_replies();

    // reload with waiters queued: queue must empty
    write_init_value(15'd3);
    for (int i = 0; i < 3; i++) send_word(OP_SIGNAL, ID_W'($urandom));
    for (int i = 0; i < 8; i++) send_word(OP_WAIT, ID_W'($urandom));
    for (int i = 0; i < 3; i++) send_word(OP_SIGNAL, ID_W'($urandom));
    drain_replies();

    // climb above the largest initial value
    write_init_value('1);
    for (int i = 0; i < CLIMB_WORDS; i++) send_word(OP_SIGNAL, ID_W'($urandom));
    send_word(OP_WAIT, 6'd9);
    send_word(OP_SIGNAL, 6'd9);
    send_word(OP_SIGNAL, 6'd54);
    drain_replies();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: init = '0;
        1: init = '1;
        2: init = 15'd1;
        3: init = INIT_W'($urandom_range(2, 6));
        4: init = INIT_W'($urandom);
        default: init = 15'd2;
      endcase
      write_init_value(init);
      if (ph == 2) hold_receiver = 1'b1;
      send_random_words(PHASE_WORDS);
      drain_replies();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/csf_pkg.sv
hdl/csf_if.sv
hdl/csf_store.sv
hdl/csf_ctrl.sv
hdl/counting_semaphore_fifo.sv
hdl/csf_checker.sv
test/csf_checker.sv
test/tb_counting_semaphore_fifo.sv
